@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/bsm_pkg.sv @@
// ----------------------------------------------------------------------------
// bsm_pkg
// Types, constants and register codes of the battery charge mismatch monitor
// ----------------------------------------------------------------------------
package bsm_pkg;

    // sizes
    localparam int WINDOW_LEN = 8;
    localparam int TABLE_ROWS = 4;
    localparam int CNT_W      = 7;
    localparam int MV_W       = 13;
    localparam int CUR_W      = 24;
    localparam int SOC_W      = 7;
    localparam int ROW_W      = 33;
    localparam int IDX_W      = 3;

    localparam logic [MV_W-1:0]  MV_ALL_ONES = {MV_W{1'b1}};
    localparam logic [SOC_W-1:0] SOC_FULL    = SOC_W'(100);
    localparam logic [SOC_W-1:0] DIFF_RESET  = SOC_W'(10);

    // register indexes
    localparam logic [IDX_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd1;
    localparam logic [IDX_W-1:0] REG_DIFF      = 3'd2;
    localparam logic [IDX_W-1:0] REG_DONE_SOC  = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROW0      = 3'd4;

    // request codes on the input side
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_CHARGE = 2'd1;
    localparam logic [1:0] REQ_RESUME = 2'd2;

    // reset causes
    localparam logic [1:0] CAUSE_NONE     = 2'd0;
    localparam logic [1:0] CAUSE_MISMATCH = 2'd1;
    localparam logic [1:0] CAUSE_DONE_LOW = 2'd2;

    // work kinds decided by the front end
    typedef enum logic [2:0] {
        KIND_IGNORE,
        KIND_CHARGE,
        KIND_RESUME,
        KIND_DISCHARGE,
        KIND_OTHER_CUR
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [MV_W-1:0]   mv;
        logic [SOC_W-1:0]  shown;
        logic              done;
    } item_t;

    typedef struct packed {
        logic                              enable;
        logic signed [CUR_W-1:0]           threshold;
        logic [SOC_W-1:0]                  diff_limit;
        logic [SOC_W-1:0]                  done_soc;
        logic [TABLE_ROWS-1:0][ROW_W-1:0]  rows;
    } cfg_t;

    typedef struct packed {
        logic              reset_request;
        logic [1:0]        reset_cause;
        logic              report_pulse;
        logic              window_done;
        logic [MV_W-1:0]   window_min_mv;
        logic [SOC_W-1:0]  estimated_soc;
    } res_t;

endpackage

@@ hw/rtl/battery_soc_mismatch_monitor.sv @@
// ----------------------------------------------------------------------------
// battery_soc_mismatch_monitor
// Watches battery samples and requests a gauge reset on a charge mismatch
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one request word: tuser is the request kind
//   (sample, charging event, resume), tdata the voltage, current, shown
//   percent and charge-done flag. m_* channel returns one result word per
//   request word, in order. cfg_we/cfg_index/cfg_data write the settings
//   while the block is idle; a write takes effect at once.
//   Path: a taken word is written into the front queue; the back end pops
//   it once its result register is free and registers its result, which
//   then shows on m_tvalid.
//   Throughput: one word per cycle while m_tready stays high, set by the
//   combinational window and table evaluation in the back end.
//   Reset: window count cleared, window minimum set to all ones, report
//   re-armed, settings to their defaults, queue and result register empty.
//   Stall: while m_tready is low the result holds; the two-entry queue
//   takes words until it holds two, then s_tready drops until the result drains.
// ----------------------------------------------------------------------------
module battery_soc_mismatch_monitor (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata: voltage_mv[12:0], battery_current[36:13], shown_soc[43:37],
    //          chg_done[44], zero padding[47:45]
    input  logic [47:0]                  s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [1:0]                   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata: reset_request[0], reset_cause[2:1], report_pulse[3],
    //          window_done[4], window_min_mv[17:5], estimated_soc[24:18],
    //          zero padding[31:25]
    output logic [31:0]                  m_tdata,
    input  logic                         cfg_we,
    input  logic [bsm_pkg::IDX_W-1:0]    cfg_index,
    input  logic [bsm_pkg::ROW_W-1:0]    cfg_data
);
    import bsm_pkg::*;

    cfg_t  cfg_reg;
    item_t f_item;
    item_t q_item;
    res_t  res;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_not_empty;

    // settings registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable     <= 1'b0;
            cfg_reg.threshold  <= '0;
            cfg_reg.diff_limit <= DIFF_RESET;
            cfg_reg.done_soc   <= '0;
            cfg_reg.rows       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:    cfg_reg.enable     <= cfg_data[0];
                REG_THRESHOLD: cfg_reg.threshold  <= cfg_data[CUR_W-1:0];
                REG_DIFF:      cfg_reg.diff_limit <= cfg_data[SOC_W-1:0];
                REG_DONE_SOC:  cfg_reg.done_soc   <= cfg_data[SOC_W-1:0];
                default:
                begin
                    for (int r = 0; r < TABLE_ROWS; r++)
                    begin
                        if (cfg_index == IDX_W'(REG_ROW0 + r))
                            cfg_reg.rows[r] <= cfg_data;
                    end
                end
            endcase
        end
    end

    // front end
    bsm_front u_front (
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .req_type        (s_tuser),
        .voltage_mv      (s_tdata[12:0]),
        .battery_current (s_tdata[36:13]),
        .shown_soc       (s_tdata[43:37]),
        .chg_done        (s_tdata[44]),
        .cfg             (cfg_reg),
        .q_full          (q_full),
        .push            (push),
        .item            (f_item)
    );

    // queue between the two halves
    bsm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item_in   (f_item),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .item_out  (q_item)
    );

    // back end
    bsm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_item      (q_item),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .res         (res)
    );

    // output word packing
    assign m_tdata = {7'd0, res.estimated_soc, res.window_min_mv, res.window_done,
                      res.report_pulse, res.reset_cause, res.reset_request};

endmodule

@@ hw/rtl/bsm_front.sv @@
// ----------------------------------------------------------------------------
// bsm_front
// Input side: takes words and sorts them into work kinds for the back end
// ----------------------------------------------------------------------------
module bsm_front (
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [1:0]                  req_type,
    input  logic [bsm_pkg::MV_W-1:0]    voltage_mv,
    input  logic [bsm_pkg::CUR_W-1:0]   battery_current,
    input  logic [bsm_pkg::SOC_W-1:0]   shown_soc,
    input  logic                        chg_done,
    input  bsm_pkg::cfg_t               cfg,
    input  logic                        q_full,
    output logic                        push,
    output bsm_pkg::item_t              item
);
    import bsm_pkg::*;

    // accept whenever the queue has room
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // classify the word
    always_comb
    begin
        item.mv    = voltage_mv;
        item.shown = shown_soc;
        item.done  = chg_done;
        case (req_type)
            REQ_CHARGE: item.kind = KIND_CHARGE;
            REQ_RESUME: item.kind = KIND_RESUME;
            REQ_SAMPLE:
            begin
                if (!cfg.enable)
                    item.kind = KIND_IGNORE;
                else if ($signed(battery_current) < cfg.threshold)
                    item.kind = KIND_DISCHARGE;
                else
                    item.kind = KIND_OTHER_CUR;
            end
            default: item.kind = KIND_IGNORE;
        endcase
    end

endmodule

@@ hw/rtl/bsm_queue.sv @@
// ----------------------------------------------------------------------------
// bsm_queue
// Two-entry queue between front end and back end
// ----------------------------------------------------------------------------
module bsm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bsm_pkg::item_t  item_in,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output bsm_pkg::item_t  item_out
);
    import bsm_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign item_out  = entry_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= item_in;
    end

endmodule

@@ hw/rtl/bsm_back.sv @@
// ----------------------------------------------------------------------------
// bsm_back
// Back end: window tracking, table lookup, reset decision and result register
// ----------------------------------------------------------------------------
module bsm_back (
    input  logic            clk,
    input  logic            rst_n,
    input  bsm_pkg::cfg_t   cfg,
    input  logic            q_not_empty,
    input  bsm_pkg::item_t  q_item,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output bsm_pkg::res_t   res
);
    import bsm_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [MV_W-1:0]  min_reg, min_next;
    logic             reported_reg, reported_next;
    logic             valid_reg, valid_next;
    res_t             res_reg, res_next;

    logic [CNT_W-1:0] win_count;
    logic [MV_W-1:0]  win_min;
    logic [SOC_W-1:0] table_pct;
    logic             mismatch;
    logic             is_sample;
    logic [ROW_W-1:0] row;

    // take a word when the result register is free or drains this cycle
    assign pop       = q_not_empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign res       = res_reg;

    // running window values
    assign win_count = count_reg + CNT_W'(1);
    assign win_min   = (q_item.mv < min_reg) ? q_item.mv : min_reg;
    assign is_sample = (q_item.kind == KIND_DISCHARGE) || (q_item.kind == KIND_OTHER_CUR);

    // first-match range table, lowest row wins
    always_comb
    begin
        table_pct = '0;
        row       = '0;
        for (int r = TABLE_ROWS - 1; r >= 0; r--)
        begin
            row = cfg.rows[r];
            if ((win_min > row[12:0]) && (win_min <= row[25:13]))
                table_pct = row[32:26];
        end
    end

    // next state and result
    always_comb
    begin
        count_next    = count_reg;
        min_next      = min_reg;
        reported_next = reported_reg;
        valid_next    = valid_reg;
        res_next      = res_reg;
        mismatch      = 1'b0;
        if (valid_reg && out_ready)
            valid_next = 1'b0;
        if (pop)
        begin
            valid_next = 1'b1;
            res_next   = '0;
            case (q_item.kind)
                KIND_CHARGE: reported_next = 1'b0;
                KIND_RESUME:
                begin
                    count_next = '0;
                    min_next   = MV_ALL_ONES;
                end
                KIND_DISCHARGE:
                begin
                    if (win_count >= CNT_W'(WINDOW_LEN))
                    begin
                        res_next.window_done   = 1'b1;
                        res_next.window_min_mv = win_min;
                        mismatch = (table_pct != '0) &&
                            ({1'b0, table_pct} > ({1'b0, q_item.shown} + {1'b0, cfg.diff_limit}));
                        count_next = '0;
                        min_next   = MV_ALL_ONES;
                    end
                    else
                    begin
                        count_next = win_count;
                        min_next   = win_min;
                    end
                end
                KIND_OTHER_CUR:
                begin
                    count_next = '0;
                    min_next   = MV_ALL_ONES;
                end
                default: ;
            endcase
            // reset decision for enabled samples
            if (is_sample)
            begin
                if (mismatch)
                begin
                    res_next.reset_request = 1'b1;
                    res_next.reset_cause   = CAUSE_MISMATCH;
                    res_next.estimated_soc = table_pct;
                end
                else if (q_item.done && (q_item.shown <= cfg.done_soc))
                begin
                    res_next.reset_request = 1'b1;
                    res_next.reset_cause   = CAUSE_DONE_LOW;
                    res_next.estimated_soc = SOC_FULL;
                end
                if (res_next.reset_request && !reported_reg)
                begin
                    reported_next         = 1'b1;
                    res_next.report_pulse = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            min_reg      <= MV_ALL_ONES;
            reported_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            min_reg      <= min_next;
            reported_reg <= reported_next;
            valid_reg    <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

@@ hw/rtl/bsm_checker.sv @@
// ----------------------------------------------------------------------------
// bsm_checker
// Port-level checks of the mismatch monitor, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result word stays offered
    `ASSERT_NEXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid)

    // no reset request means no cause, no estimate and no report pulse
    `ASSERT_IMPLIES(a_no_req, clk, rst_n, m_tvalid && !m_tdata[0], (m_tdata[2:1] == 2'd0) && (m_tdata[24:18] == 7'd0) && !m_tdata[3])

    // charge-done cause always reports a full estimate
    `ASSERT_IMPLIES(a_done_est, clk, rst_n, m_tvalid && (m_tdata[2:1] == 2'd2), m_tdata[24:18] == 7'd100)

    // mismatch only comes out of an evaluated window with a nonzero estimate
    `ASSERT_IMPLIES(a_mismatch_win, clk, rst_n, m_tvalid && (m_tdata[2:1] == 2'd1), m_tdata[4] && (m_tdata[24:18] != 7'd0))

    // window minimum is zero unless a window was evaluated
    `ASSERT_IMPLIES(a_min_zero, clk, rst_n, m_tvalid && !m_tdata[4], m_tdata[17:5] == 13'd0)

endmodule

bind battery_soc_mismatch_monitor bsm_checker u_bsm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the battery charge mismatch monitor: sends request
// words under random source gaps and sink stalls, predicts every result word
// from its own copy of the window, report and settings state, and compares
// each result field by field in arrival order
// ----------------------------------------------------------------------------
module tb;

    import bsm_pkg::*;

    localparam int CYCLE_LIMIT = 100000;

    // request code the block has no use for
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic signed [CUR_W-1:0] CUR_MIN = 24'sh800000;
    localparam logic signed [CUR_W-1:0] CUR_MAX = 24'sh7FFFFF;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [47:0]         s_tdata   = '0;
    logic [1:0]          s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [31:0]         m_tdata;
    logic                cfg_we    = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [ROW_W-1:0]    cfg_data  = '0;

    // settings as the block should hold them
    logic                    cfg_enable     = 1'b0;
    logic signed [CUR_W-1:0] cfg_threshold  = '0;
    logic [SOC_W-1:0]        cfg_diff_limit = DIFF_RESET;
    logic [SOC_W-1:0]        cfg_done_soc   = '0;
    logic [ROW_W-1:0]        cfg_rows [TABLE_ROWS] = '{default: '0};

    // discharge window and report state
    logic [CNT_W-1:0]    disch_count    = '0;
    logic [MV_W-1:0]     disch_min_mv   = MV_ALL_ONES;
    logic                reset_reported = 1'b0;

    res_t                pending_verdicts [$];
    res_t                verdict;
    int                  errors      = 0;
    int                  cycle_count = 0;
    bit                  no_idle     = 1'b0;

    battery_soc_mismatch_monitor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // sink stalls
    always @(posedge clk)
    begin
        m_tready <= no_idle || ($urandom_range(99) >= 6);
    end

    // first-match percent lookup, scanned from the last row so row 0 wins
    function automatic logic [SOC_W-1:0] lookup_soc(input logic [MV_W-1:0] mv);
        logic [SOC_W-1:0] pct;
        pct = '0;
        for (int r = TABLE_ROWS - 1; r >= 0; r--)
        begin
            if (mv > cfg_rows[r][12:0] && mv <= cfg_rows[r][25:13])
                pct = cfg_rows[r][32:26];
        end
        return pct;
    endfunction

    // advance the window state for one accepted word and queue its result
    task automatic predict_result(input logic [1:0] req, input logic [MV_W-1:0] mv,
                                  input logic signed [CUR_W-1:0] cur,
                                  input logic [SOC_W-1:0] shown, input logic done);
        res_t             r;
        logic [SOC_W-1:0] pct;
        logic             mismatch;
        r        = '0;
        pct      = '0;
        mismatch = 1'b0;
        if (req == REQ_CHARGE)
        begin
            reset_reported = 1'b0;
        end
        else if (req == REQ_RESUME)
        begin
            disch_count  = '0;
            disch_min_mv = MV_ALL_ONES;
        end
        else if (req == REQ_SAMPLE && cfg_enable)
        begin
            if (cur < cfg_threshold)
            begin
                if (mv < disch_min_mv)
                    disch_min_mv = mv;
                disch_count = disch_count + 1'b1;
            end
            else
            begin
                disch_count  = '0;
                disch_min_mv = MV_ALL_ONES;
            end
            // full window: look up the minimum and start over
            if (disch_count >= WINDOW_LEN)
            begin
                r.window_done   = 1'b1;
                r.window_min_mv = disch_min_mv;
                pct             = lookup_soc(disch_min_mv);
                mismatch        = (pct != '0) &&
                                  (int'(pct) - int'(shown) > int'(cfg_diff_limit));
                disch_count     = '0;
                disch_min_mv    = MV_ALL_ONES;
            end
            if (mismatch)
            begin
                r.reset_request = 1'b1;
                r.reset_cause   = CAUSE_MISMATCH;
                r.estimated_soc = pct;
            end
            else if (shown <= cfg_done_soc && done)
            begin
                r.reset_request = 1'b1;
                r.reset_cause   = CAUSE_DONE_LOW;
                r.estimated_soc = SOC_FULL;
            end
            if (r.reset_request && !reset_reported)
            begin
                reset_reported = 1'b1;
                r.report_pulse = 1'b1;
            end
        end
        pending_verdicts.push_back(r);
    endtask

    // one request word, with a random gap ahead of it
    task automatic send_word(input logic [1:0] req, input logic [MV_W-1:0] mv,
                             input logic signed [CUR_W-1:0] cur,
                             input logic [SOC_W-1:0] shown, input logic done);
        while (!no_idle && $urandom_range(99) < 6)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {3'b000, done, shown, cur, mv};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_result(req, mv, cur, shown, done);
    endtask

    // hold the source until every queued result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_ENABLE:    cfg_enable     = val[0];
            REG_THRESHOLD: cfg_threshold  = val[CUR_W-1:0];
            REG_DIFF:      cfg_diff_limit = val[SOC_W-1:0];
            REG_DONE_SOC:  cfg_done_soc   = val[SOC_W-1:0];
            default:       cfg_rows[2'(idx - REG_ROW0)] = val;
        endcase
    endtask

    task automatic check_field(input string name, input int exp_val, input int got_val);
        if (exp_val != got_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            errors++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result word %h with nothing expected", m_tdata);
                errors++;
            end
            else
            begin
                verdict = pending_verdicts.pop_front();
                check_field("reset_request", verdict.reset_request, m_tdata[0]);
                check_field("reset_cause",   verdict.reset_cause,   m_tdata[2:1]);
                check_field("report_pulse",  verdict.report_pulse,  m_tdata[3]);
                check_field("window_done",   verdict.window_done,   m_tdata[4]);
                check_field("window_min_mv", verdict.window_min_mv, m_tdata[17:5]);
                check_field("estimated_soc", verdict.estimated_soc, m_tdata[24:18]);
                check_field("padding",       0,                     m_tdata[31:25]);
            end
        end
    end

    // random words, mostly discharge runs with voltages inside table rows
    task automatic send_random_words(input int count);
        int                      roll;
        logic [1:0]              row;
        longint                  span;
        logic [1:0]              req;
        logic [MV_W-1:0]         mv;
        logic signed [CUR_W-1:0] cur;
        logic [SOC_W-1:0]        shown;
        logic                    done;
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (roll < 90)
                req = REQ_SAMPLE;
            else if (roll < 94)
                req = REQ_CHARGE;
            else if (roll < 97)
                req = REQ_RESUME;
            else
                req = REQ_UNUSED;
            if ($urandom_range(99) < 92 && cfg_threshold != CUR_MIN)
            begin
                span = longint'(cfg_threshold) + 8388608;
                cur  = CUR_W'(longint'(cfg_threshold) - 1
                              - longint'($urandom_range(32'(span - 1))));
            end
            else
            begin
                span = 8388608 - longint'(cfg_threshold);
                cur  = CUR_W'(longint'(cfg_threshold)
                              + longint'($urandom_range(32'(span - 1))));
            end
            row = 2'($urandom_range(TABLE_ROWS - 1));
            if ($urandom_range(9) < 7 && cfg_rows[row][12:0] < cfg_rows[row][25:13])
                mv = MV_W'($urandom_range(cfg_rows[row][25:13], cfg_rows[row][12:0] + 1));
            else
                mv = MV_W'($urandom_range(8191));
            shown = SOC_W'(($urandom_range(99) < 85) ? $urandom_range(100)
                                                      : $urandom_range(127));
            done  = ($urandom_range(3) == 0);
            send_word(req, mv, cur, shown, done);
        end
    endtask

    // random settings, ascending rows with an occasional overlap or garbage row
    task automatic load_random_settings();
        int                      roll;
        logic signed [CUR_W-1:0] thr;
        logic [MV_W-1:0]         lo_mv;
        logic [MV_W-1:0]         hi_mv;
        logic [SOC_W-1:0]        pct;
        logic [ROW_W-1:0]        row_val;
        write_reg(REG_ENABLE, ROW_W'($urandom_range(9) != 0));
        roll = $urandom_range(9);
        if (roll == 0)
            thr = CUR_MIN;
        else if (roll == 1)
            thr = CUR_MAX;
        else if (roll < 6)
            thr = CUR_W'(int'($urandom_range(2000)) - 1000);
        else
            thr = CUR_W'($urandom);
        write_reg(REG_THRESHOLD, {{(ROW_W-CUR_W){1'b0}}, thr});
        write_reg(REG_DIFF, ROW_W'(($urandom_range(9) == 0) ? $urandom_range(127)
                                                            : $urandom_range(100)));
        roll = $urandom_range(9);
        write_reg(REG_DONE_SOC, ROW_W'((roll == 0) ? $urandom_range(127)
                                                   : $urandom_range(40)));
        hi_mv = MV_W'($urandom_range(3500, 2500));
        for (int r = 0; r < TABLE_ROWS; r++)
        begin
            lo_mv = MV_W'(($urandom_range(4) == 0) ? hi_mv - $urandom_range(100)
                                                   : 32'(hi_mv));
            hi_mv = MV_W'(lo_mv + $urandom_range(400));
            roll  = $urandom_range(99);
            if (roll < 70)
                pct = SOC_W'($urandom_range(100));
            else if (roll < 85)
                pct = '0;
            else
                pct = SOC_W'($urandom_range(127, 101));
            if ($urandom_range(9) == 0)
                row_val = {1'($urandom_range(1)), $urandom};
            else
                row_val = {pct, hi_mv, lo_mv};
            write_reg(IDX_W'(REG_ROW0 + r), row_val);
        end
    endtask

    // samples, charging and unused codes while the monitor is still off
    task automatic test_monitor_off();
        send_word(REQ_SAMPLE, 13'h1FFF, CUR_MIN, 7'd127, 1'b1);
        send_word(REQ_SAMPLE, 13'h0000, CUR_MAX, 7'd0, 1'b1);
        send_word(REQ_CHARGE, 13'h0AAA, 24'sh555555, 7'h2A, 1'b0);
        send_word(REQ_UNUSED, 13'h1555, 24'sh2AAAAA, 7'h55, 1'b1);
    endtask

    // full discharge window whose estimate is far above the shown percent
    task automatic test_mismatch_window();
        wait_idle();
        write_reg(REG_ENABLE, ROW_W'(1));
        write_reg(REG_THRESHOLD, ROW_W'(0));
        write_reg(REG_DIFF, ROW_W'(10));
        write_reg(REG_DONE_SOC, ROW_W'(20));
        write_reg(REG_ROW0, {7'd5, 13'd3400, 13'd3000});
        write_reg(IDX_W'(REG_ROW0 + 1), {7'd0, 13'd3600, 13'd3400});
        write_reg(IDX_W'(REG_ROW0 + 2), {7'd60, 13'd3800, 13'd3600});
        write_reg(IDX_W'(REG_ROW0 + 3), {7'd127, 13'd8191, 13'd3700});
        send_word(REQ_SAMPLE, 13'd3900, CUR_W'(-500), 7'd10, 1'b0);
        send_word(REQ_SAMPLE, 13'd3850, CUR_MIN, 7'd10, 1'b0);
        send_word(REQ_SAMPLE, 13'd3780, CUR_W'(-1), 7'd10, 1'b0);
        send_word(REQ_SAMPLE, 13'd3650, CUR_W'(-700), 7'd10, 1'b0);
        send_word(REQ_SAMPLE, 13'd3700, CUR_W'(-900), 7'd10, 1'b0);
        send_word(REQ_SAMPLE, 13'd3720, CUR_W'(-300), 7'd10, 1'b0);
        send_word(REQ_SAMPLE, 13'd3690, CUR_W'(-800), 7'd10, 1'b0);
        send_word(REQ_SAMPLE, 13'd3660, CUR_W'(-200), 7'd10, 1'b0);
        // charging event re-arms the report
        send_word(REQ_CHARGE, 13'd4000, 24'sd1000, 7'd50, 1'b1);
    endtask

    // charge done at a low shown percent, current equal to the threshold
    task automatic test_done_low_cause();
        send_word(REQ_SAMPLE, 13'd4100, CUR_W'(0), 7'd20, 1'b1);
        send_word(REQ_SAMPLE, 13'd4100, CUR_MAX, 7'd20, 1'b1);
    endtask

    // resume and a non-discharge current break a window, then a window
    // lands in a zero-percent row and reports without a reset
    task automatic test_window_breaks();
        send_word(REQ_SAMPLE, 13'd3500, CUR_W'(-1), 7'd50, 1'b0);
        send_word(REQ_SAMPLE, 13'd3550, CUR_W'(-2000), 7'd50, 1'b0);
        send_word(REQ_RESUME, 13'h1FFF, CUR_MIN, 7'd127, 1'b1);
        send_word(REQ_SAMPLE, 13'd3450, CUR_W'(-3), 7'd50, 1'b0);
        send_word(REQ_SAMPLE, 13'd3300, CUR_W'(5), 7'd50, 1'b0);
        for (int i = 0; i < WINDOW_LEN; i++)
            send_word(REQ_SAMPLE, MV_W'((i == 5) ? 3420 : 3590 - i), CUR_W'(-10 - i),
                      7'd0, 1'b0);
    endtask

    // extreme thresholds, limits and rows
    task automatic test_register_extremes();
        wait_idle();
        write_reg(REG_THRESHOLD, {{(ROW_W-CUR_W){1'b0}}, CUR_MAX});
        write_reg(REG_DIFF, ROW_W'(0));
        write_reg(REG_DONE_SOC, ROW_W'(100));
        write_reg(REG_ROW0, {ROW_W{1'b1}});
        write_reg(IDX_W'(REG_ROW0 + 1), {7'd127, 13'd3600, 13'd3000});
        write_reg(IDX_W'(REG_ROW0 + 2), {7'd0, 13'd4000, 13'd3600});
        write_reg(IDX_W'(REG_ROW0 + 3), {7'd100, 13'd8191, 13'd0});
        send_random_words(40);
        wait_idle();
        write_reg(REG_THRESHOLD, {{(ROW_W-CUR_W){1'b0}}, CUR_MIN});
        write_reg(REG_DIFF, ROW_W'(100));
        write_reg(REG_DONE_SOC, ROW_W'(0));
        send_random_words(20);
    endtask

    // random settings phases; one phase runs without idling, one drains midway
    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++)
        begin
            wait_idle();
            load_random_settings();
            no_idle = (phase == 3);
            send_random_words(22);
            if (phase == 5)
                wait_idle();
            send_random_words(22);
        end
        no_idle = 1'b0;
    endtask

    // test sequence
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_monitor_off();
        test_mismatch_window();
        test_done_low_cause();
        test_window_breaks();
        test_register_extremes();
        test_random_traffic();
        wait_idle();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
